// ===== sv/jac_pkg.sv =====
// Shared types and constants for the joystick axis calibrator.
`default_nettype none
package jac_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int VALUE_W   = 8;
  localparam int CH_W      = 2;
  localparam int NUM_AXES  = 4;
  localparam int CFG_IDX_W = 4;
  localparam int NUMER_W   = SAMPLE_W + VALUE_W;
  localparam int QSTEP_W   = 3;

  typedef logic [SAMPLE_W-1:0] cal_word_t;
  typedef logic [CH_W-1:0]     chan_t;
  typedef logic [VALUE_W-1:0]  axis_val_t;
  typedef logic [NUMER_W-1:0]  numer_t;

  localparam cal_word_t SAMPLE_MAX = 10'd1023;

  // register map: offsets at 0..3, spans at 4..7
  localparam logic [CFG_IDX_W-1:0] REG_SPAN_BASE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END       = 4'd8;

  localparam cal_word_t OFFSET_RESET [NUM_AXES] = '{10'd450, 10'd400, 10'd430, 10'd400};
  localparam cal_word_t SPAN_RESET   [NUM_AXES] = '{10'd150, 10'd200, 10'd200, 10'd200};

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

// ===== sv/jac_ifs.sv =====
// Valid/ready stream interfaces for sample input and calibrated output.
`default_nettype none
interface jac_in_if;
  logic                         valid;
  logic                         ready;
  logic [jac_pkg::SAMPLE_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface jac_out_if;
  logic                        valid;
  logic                        ready;
  logic [jac_pkg::CH_W-1:0]    axis_channel;
  logic [jac_pkg::VALUE_W-1:0] axis_value;
  logic                        round_done;

  modport source (output valid, output axis_channel, output axis_value,
                  output round_done, input ready);
  modport sink   (input valid, input axis_channel, input axis_value,
                  input round_done, output ready);
endinterface
`default_nettype wire

// ===== sv/jac_cal_regs.sv =====
// Calibration register file: per-channel offset and span, read by channel.
`default_nettype none
module jac_cal_regs (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [jac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [jac_pkg::SAMPLE_W-1:0]    cfg_data,
  input  wire jac_pkg::chan_t                  sel_ch,
  output jac_pkg::cal_word_t                   sel_offset,
  output jac_pkg::cal_word_t                   sel_span
);
  import jac_pkg::*;

  cal_word_t offset_r [NUM_AXES];
  cal_word_t span_r   [NUM_AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        offset_r[i] <= OFFSET_RESET[i];
        span_r[i]   <= SPAN_RESET[i];
      end
    end else if (cfg_we) begin
      // indexes past the span block are dropped
      priority if (cfg_index < REG_SPAN_BASE) begin
        offset_r[cfg_index[CH_W-1:0]] <= cfg_data;
      end else if (cfg_index < REG_END) begin
        span_r[cfg_index[CH_W-1:0]] <= cfg_data;
      end
    end
  end

  assign sel_offset = offset_r[sel_ch];
  assign sel_span   = span_r[sel_ch];

endmodule
`default_nettype wire

// ===== sv/jac_divider.sv =====
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
`default_nettype none
module jac_divider (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire jac_pkg::numer_t      numer,
  input  wire jac_pkg::cal_word_t   denom,
  output jac_pkg::div_stat_t        stat,
  output jac_pkg::axis_val_t        quot
);
  import jac_pkg::*;

  localparam int DSH_W = SAMPLE_W + VALUE_W - 1;

  numer_t                 rem_r;
  logic [DSH_W-1:0]       dsh_r;
  axis_val_t              quot_r;
  logic [QSTEP_W-1:0]     step_r;
  logic                   busy_r;
  logic                   done_r;

  logic                   ge;
  numer_t                 dsh_ext;

  // numerator is below 256*denom, so eight trial subtracts cover the quotient
  assign dsh_ext = {1'b0, dsh_r};
  assign ge      = (rem_r >= dsh_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= QSTEP_W'(VALUE_W - 1);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= numer;
      dsh_r  <= {denom, {(VALUE_W-1){1'b0}}};
      quot_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsh_ext;
      end
      dsh_r  <= dsh_r >> 1;
      quot_r <= {quot_r[VALUE_W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quot_r;

endmodule
`default_nettype wire

// ===== sv/joystick_axis_calibrator.sv =====
// Top level of the joystick axis calibrator: sequencer, channel state, output register.
//
// Usage:
//   in_ch  (valid/ready) carries one 10-bit converter sample per item, taken in
//          round-robin channel order starting at channel 0 after reset.
//   out_ch (valid/ready) returns one item per sample: channel, 0..255 value,
//          and round_done on the last channel of a round.
//   cfg_*  writes offset (index 0..3) and span (index 4..7) registers; other
//          indexes are dropped. Write only while no sample is in flight.
// Sequence:
//   Sample accepted in IDLE, then invert/offset/clamp in PREP, reading*255 formed
//   and the divider started in MUL, the bit-serial divide in DIV until its done
//   flag, then the output register loaded in DONE. A new sample is accepted only
//   once the previous one has left DONE, so samples are never overlapped.
// Reset: channel index returns to 0, calibration registers to their defaults,
//   output register empties.
// Stall: the output register holds its item until taken; the next sample is
//   accepted and computed meanwhile, and waits in the final step until the
//   output register frees up.
`default_nettype none
module joystick_axis_calibrator #(
  parameter int NUM_CHANNELS = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  jac_in_if.sink                               in_ch,
  jac_out_if.source                            out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [jac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [jac_pkg::SAMPLE_W-1:0]    cfg_data
);
  import jac_pkg::*;

  localparam chan_t LAST_CH = CH_W'(NUM_CHANNELS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t     state_r;
  chan_t      ch_r;
  cal_word_t  raw_r;
  cal_word_t  rd_r;
  cal_word_t  rd_nxt;

  logic       out_valid_r;
  chan_t      out_ch_r;
  axis_val_t  out_val_r;
  logic       out_last_r;

  cal_word_t  offset;
  cal_word_t  span;
  cal_word_t  inv;
  numer_t     numer;
  logic       div_start;
  div_stat_t  div_stat;
  axis_val_t  quot;
  logic       is_last;
  logic       out_free;

  jac_cal_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sel_ch     (ch_r),
    .sel_offset (offset),
    .sel_span   (span)
  );

  jac_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (numer),
    .denom (span),
    .stat  (div_stat),
    .quot  (quot)
  );

  // even channels read inverted
  assign inv = ch_r[0] ? raw_r : (SAMPLE_MAX - raw_r);

  // floor at zero after the offset, then clamp to span
  always_comb begin
    rd_nxt = (inv < offset) ? '0 : (inv - offset);
    if (rd_nxt > span) begin
      rd_nxt = span;
    end
  end

  // reading*255 as reading*256 - reading
  assign numer     = {rd_r, {VALUE_W{1'b0}}} - {{VALUE_W{1'b0}}, rd_r};
  assign div_start = (state_r == S_MUL);
  assign is_last   = (ch_r >= LAST_CH);
  assign out_free  = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // load wins over the take of the previous item
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            raw_r   <= in_ch.raw_sample;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          rd_r    <= rd_nxt;
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_ch_r    <= ch_r;
            // zero span would divide by zero; value is zero then
            out_val_r   <= (span == '0) ? '0 : quot;
            out_last_r  <= is_last;
            ch_r        <= is_last ? '0 : ch_r + 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.axis_channel = out_ch_r;
  assign out_ch.axis_value   = out_val_r;
  assign out_ch.round_done   = out_last_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider finished outside the divide step");

  a_rd_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> rd_r <= span)
    else $error("clamped reading exceeds span");

  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    ch_r <= LAST_CH)
    else $error("channel index past last channel");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_last_r == (out_ch_r >= LAST_CH))
    else $error("round_done does not match channel");

  a_div_busy_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> state_r == S_DIV)
    else $error("divider running outside the divide step");

endmodule
`default_nettype wire
